>>> hdl/vfpid_pkg.sv
// Shared constants and helpers for the velocity-form PID core.
package vfpid_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_GAIN_P = 2'd0;
   localparam logic [1:0] REG_GAIN_I = 2'd1;
   localparam logic [1:0] REG_GAIN_D = 2'd2;

   // Widths of the serial datapath.
   localparam int MAG_W = 52;            // widest term magnitude
   localparam int PROD_W = 2 * MAG_W;    // full product of two magnitudes
   localparam int ACC_W = 72;            // exact sum of all terms
   localparam int DIVD_W = 51;           // |numerator| * 2^16
   localparam int DIVS_W = 33;           // |T0|

   // Iteration counts of the shift-add multiplier and the restoring divider.
   localparam int MUL_STEPS = MAG_W;
   localparam int DIV_STEPS = DIVD_W;
   localparam int CNT_W = 6;

   typedef logic [CNT_W-1:0] count_type;

   // Magnitude of a 35-bit two's complement value, as an unsigned pattern.
   function automatic logic [34:0] mag35(input logic [34:0] x);
      logic [34:0] r;
      r = x[34] ? (35'd0 - x) : x;
      return r;
   endfunction

endpackage

>>> hdl/velocity_form_pid_core.sv
// Top level of the velocity-form PID core with its serial multiplier and divider.
//
// One sample runs from acceptance to a valid result through PREP, IMUL, DPREP,
// DIV (when the derivative needs a division), GPREP/GMUL per gain and DONE. A
// single shift-add multiplier retiring one multiplier bit per cycle forms the
// integral product and then each of the three gain products (a load step, the
// shift steps and an accumulate step). A restoring divider producing one
// quotient bit per cycle forms the derivative, skipped when no division is
// needed. The PREP and DPREP states prepare operands and DONE saturates the sum.
// The core takes one sample at a time: req_stall drops in the same cycle that
// the result register is loaded, and a new sample is taken even while the
// previous result still waits on a stall.
module velocity_form_pid_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_sample_time,
   input  logic signed [31:0]  req_setpoint,
   input  logic signed [31:0]  req_measurement,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_control_value,
   output logic                rsp_zero_interval,
   output logic                rsp_saturated,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import vfpid_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_IMUL  = 3'd2;
   localparam logic [2:0] ST_DPREP = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_GPREP = 3'd5;
   localparam logic [2:0] ST_GMUL  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   count_type cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;

   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [31:0] last_time_ff;
   logic [32:0] last_error_ff, older_error_ff;
   logic [31:0] last_control_ff, last_control_in;

   // Working copies of one sample.
   logic [32:0] t0_ff, e1_ff;
   logic [33:0] p_ff;
   logic [34:0] num_ff;
   logic lt_pos_ff, z_ff, z_in;

   logic [MAG_W-1:0] tmag_ff [3];
   logic [MAG_W-1:0] tmag_in [3];
   logic [2:0] tsign_ff, tsign_in;

   logic [MAG_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic tsel_sign_ff, tsel_sign_in;
   logic [DIVD_W-1:0] divd_ff, divd_in;
   logic [DIVS_W-1:0] divs_ff, divs_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] ctl_ff, ctl_in;
   logic zo_ff, zo_in, sat_ff, sat_in;

   logic req_take;
   logic [32:0] e_now, t0_now;
   logic [33:0] p_now;
   logic [34:0] num_now;
   logic [MAG_W:0] mul_sum;
   logic [DIVS_W:0] rem_shift;
   logic rem_ge;
   logic [34:0] t0_mag, gain_mag, x_mag;
   logic [31:0] gain_sel;
   logic [ACC_W-1:0] term;
   logic in_range;
   logic cfg_write;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GAIN_P: csr_prdata = gain_p_ff;
         REG_GAIN_I: csr_prdata = gain_i_ff;
         REG_GAIN_D: csr_prdata = gain_d_ff;
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 32'd0;
         gain_i_ff <= 32'd0;
         gain_d_ff <= 32'd0;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_GAIN_P: gain_p_ff <= csr_pwdata;
            REG_GAIN_I: gain_i_ff <= csr_pwdata;
            REG_GAIN_D: gain_d_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Input beat and the sample's error terms.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign e_now = {req_setpoint[31], req_setpoint} - {req_measurement[31], req_measurement};
   assign t0_now = {1'b0, req_sample_time} - {1'b0, last_time_ff};
   assign p_now = {e_now[32], e_now} - {last_error_ff[32], last_error_ff};
   assign num_now = {{2{e_now[32]}}, e_now}
                  - {last_error_ff[32], last_error_ff, 1'b0}
                  + {{2{older_error_ff[32]}}, older_error_ff};

   // Shared datapath pieces.
   assign mul_sum = {1'b0, prod_ff[PROD_W-1:MAG_W]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign rem_shift = {rem_ff, divd_ff[DIVD_W-1]};
   assign rem_ge = (rem_shift >= {1'b0, divs_ff});
   assign t0_mag = mag35({{2{t0_ff[32]}}, t0_ff});
   assign term = prod_ff[ACC_W+15:16];
   assign in_range = (acc_ff[ACC_W-1:31] == '0) || (acc_ff[ACC_W-1:31] == '1);

   always_comb begin
      case (k_ff)
         2'd0:    gain_sel = gain_p_ff;
         2'd1:    gain_sel = gain_i_ff;
         default: gain_sel = gain_d_ff;
      endcase
   end
   assign gain_mag = mag35({{3{gain_sel[31]}}, gain_sel});
   assign x_mag = lt_pos_ff ? mag35(num_ff) : mag35({p_ff[33], p_ff});

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      z_in = z_ff;
      tmag_in = tmag_ff;
      tsign_in = tsign_ff;
      mcand_in = mcand_ff;
      prod_in = prod_ff;
      tsel_sign_in = tsel_sign_ff;
      divd_in = divd_ff;
      divs_in = divs_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      last_control_in = last_control_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl_in = ctl_ff;
      zo_in = zo_ff;
      sat_in = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_PREP;
               z_in = 1'b0;
            end
         end
         ST_PREP: begin
            // Integral product |e1| * |T0| and the proportional term.
            mcand_in = {{(MAG_W-35){1'b0}}, mag35({{2{e1_ff[32]}}, e1_ff})};
            prod_in = {{MAG_W{1'b0}}, {(MAG_W-35){1'b0}}, t0_mag};
            tsign_in[1] = e1_ff[32] ^ t0_ff[32];
            tmag_in[0] = {{(MAG_W-35){1'b0}}, mag35({p_ff[33], p_ff})};
            tsign_in[0] = p_ff[33];
            acc_in = {{(ACC_W-32){last_control_ff[31]}}, last_control_ff};
            cnt_in = '0;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            prod_in = {mul_sum, prod_ff[MAG_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_DPREP;
            end
         end
         ST_DPREP: begin
            // Pick the derivative form and load the divider.
            tmag_in[1] = prod_ff[MAG_W+15:16];
            tmag_in[2] = '0;
            tsign_in[2] = 1'b0;
            divd_in = {x_mag, 16'd0};
            divs_in = t0_mag[DIVS_W-1:0];
            rem_in = '0;
            cnt_in = '0;
            k_in = 2'd0;
            state_in = ST_GPREP;
            if (lt_pos_ff) begin
               if (t0_ff != '0) begin
                  tsign_in[2] = num_ff[34] ^ t0_ff[32];
                  state_in = ST_DIV;
               end else begin
                  z_in = 1'b1;
               end
            end else if (!t0_ff[32] && (t0_ff != '0)) begin
               tsign_in[2] = p_ff[33];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ge) begin
               rem_in = DIVS_W'(rem_shift - {1'b0, divs_ff});
            end else begin
               rem_in = rem_shift[DIVS_W-1:0];
            end
            divd_in = {divd_ff[DIVD_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_GPREP;
               k_in = 2'd0;
            end
         end
         ST_GPREP: begin
            // Keep the quotient when arriving from the divider, then load the next product.
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               tmag_in[2] = {1'b0, divd_ff};
            end
            mcand_in = {{(MAG_W-35){1'b0}}, gain_mag};
            prod_in = {{MAG_W{1'b0}}, tmag_ff[k_ff]};
            tsel_sign_in = gain_sel[31] ^ tsign_ff[k_ff];
            cnt_in = '0;
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            prod_in = {mul_sum, prod_ff[MAG_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               // Product complete: accumulate it with its sign.
               prod_in = prod_ff;
               acc_in = tsel_sign_ff ? (acc_ff - term) : (acc_ff + term);
               cnt_in = '0;
               if (k_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_GPREP;
               end
            end
         end
         ST_DONE: begin
            // Saturate and hand the result to the output register.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               zo_in = z_ff;
               sat_in = !in_range;
               if (in_range) begin
                  ctl_in = acc_ff[31:0];
               end else begin
                  ctl_in = acc_ff[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end
               last_control_in = ctl_in;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and sample history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         k_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         last_time_ff <= 32'd0;
         last_error_ff <= 33'd0;
         older_error_ff <= 33'd0;
         last_control_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         last_control_ff <= last_control_in;
         if (req_take) begin
            last_time_ff <= req_sample_time;
            older_error_ff <= last_error_ff;
            last_error_ff <= e_now;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         t0_ff <= t0_now;
         e1_ff <= last_error_ff;
         p_ff <= p_now;
         num_ff <= num_now;
         lt_pos_ff <= (last_time_ff != 32'd0);
      end
      z_ff <= z_in;
      tmag_ff <= tmag_in;
      tsign_ff <= tsign_in;
      mcand_ff <= mcand_in;
      prod_ff <= prod_in;
      tsel_sign_ff <= tsel_sign_in;
      divd_ff <= divd_in;
      divs_ff <= divs_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      ctl_ff <= ctl_in;
      zo_ff <= zo_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_control_value = ctl_ff;
   assign rsp_zero_interval = zo_ff;
   assign rsp_saturated = sat_ff;

   // Checks.
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_PREP)
      else $error("accepted sample did not start the sequence");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_control_value == 32'h7FFF_FFFF) || (rsp_control_value == 32'h8000_0000))
      else $error("saturated result is not at a range limit");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MUL_STEPS))
      else $error("step counter overran");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_control_value))
      else $error("stalled result changed");

endmodule
